// ===== hw/rtl/lzsw_pkg.sv =====
// Shared types and constants for the LZSS window decoder.
package lzsw_pkg;

    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;
    localparam int DIST_W    = 12;
    localparam int LEN_W     = 4;
    localparam int OUT_LEN_W = 32;

    // Command queue between the parser and the copy engine.
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // One token for the copy engine: a literal byte in data[7:0], or a match
    // word with the distance in the low 12 bits and the length code on top.
    typedef struct packed {
        logic              is_match;
        logic [WORD_W-1:0] data;
    } t_cmd;

endpackage

// ===== hw/rtl/lzsw_front.sv =====
// Token parser: splits the compressed stream into literal and match commands.
module lzsw_front import lzsw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_full,
    output logic              o_push,
    output t_cmd              o_push_cmd
);

    localparam logic [1:0] PH_FLAG     = 2'd0;
    localparam logic [1:0] PH_TOKEN    = 2'd1;
    localparam logic [1:0] PH_MATCH_HI = 2'd2;

    logic [1:0]        r_phase;
    logic [BYTE_W-1:0] r_flag;
    logic [3:0]        r_tokens;
    logic [BYTE_W-1:0] r_match_low;

    logic       accept;
    logic [3:0] tokens_dec;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;
    assign tokens_dec = r_tokens - 4'd1;

    always_comb begin
        o_push              = 1'b0;
        o_push_cmd.is_match = 1'b0;
        o_push_cmd.data     = {{(WORD_W-BYTE_W){1'b0}}, i_in_byte};
        unique case (r_phase)
            PH_TOKEN: begin
                o_push = accept && !r_flag[0];
            end
            PH_MATCH_HI: begin
                o_push              = accept;
                o_push_cmd.is_match = 1'b1;
                o_push_cmd.data     = {i_in_byte, r_match_low};
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FLAG;
            r_flag      <= '0;
            r_tokens    <= '0;
            r_match_low <= '0;
        end else if (accept) begin
            unique case (r_phase)
                PH_TOKEN: begin
                    if (!r_flag[0]) begin
                        r_flag   <= r_flag >> 1;
                        r_tokens <= tokens_dec;
                        r_phase  <= (tokens_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
                    end else begin
                        r_match_low <= i_in_byte;
                        r_phase     <= PH_MATCH_HI;
                    end
                end
                PH_MATCH_HI: begin
                    r_flag   <= r_flag >> 1;
                    r_tokens <= tokens_dec;
                    r_phase  <= (tokens_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
                end
                default: begin
                    // The unused phase code behaves like a flag byte is expected.
                    r_flag   <= i_in_byte;
                    r_tokens <= 4'd8;
                    r_phase  <= PH_TOKEN;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/lzsw_queue.sv =====
// Small command FIFO between the parser and the copy engine.
module lzsw_queue import lzsw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QCW-1:0] r_count;

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QAW'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QAW'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/lzsw_back.sv =====
// Copy engine: ring window, match copy, length limit and output register.
module lzsw_back import lzsw_pkg::*; #(
    parameter int WINDOW_SIZE = 8192
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [OUT_LEN_W-1:0] i_cfg_data,
    input  logic                 i_cmd_valid,
    input  t_cmd                 i_cmd,
    output logic                 o_cmd_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [BYTE_W-1:0]    o_out_byte,
    output logic                 o_run_last,
    output logic                 o_stream_done
);

    localparam int              AW        = $clog2(WINDOW_SIZE);
    localparam logic [AW-1:0]   LAST_ADDR = AW'(WINDOW_SIZE - 1);
    localparam logic [AW:0]     WIN_EXT   = (AW+1)'(WINDOW_SIZE);

    logic [BYTE_W-1:0]    r_window [WINDOW_SIZE];
    logic [BYTE_W-1:0]    r_rd;

    logic [OUT_LEN_W-1:0] r_out_len;
    logic [OUT_LEN_W-1:0] r_produced;
    logic [AW-1:0]        r_wpos;
    logic                 r_wrapped;

    logic                 r_busy;
    logic [LEN_W:0]       r_rem;
    logic [AW-1:0]        r_src;

    logic                 r_d_valid;
    logic                 r_d_lit;
    logic [BYTE_W-1:0]    r_d_litbyte;
    logic                 r_d_last;
    logic                 r_d_fill;
    logic                 r_byp;
    logic [BYTE_W-1:0]    r_byp_data;

    logic                 r_o_valid;
    logic [BYTE_W-1:0]    r_o_byte;
    logic                 r_o_last;
    logic                 r_o_done;

    logic                 out_free;
    logic                 d_adv;
    logic                 can_issue;
    logic [DIST_W-1:0]    match_dist;
    logic [AW:0]          diff;
    logic [AW-1:0]        src0;
    logic                 start_lit;
    logic                 start_match;
    logic                 issue_cont;
    logic                 re;
    logic [AW-1:0]        ra;
    logic [AW-1:0]        src_inc;
    logic                 fill_ok;
    logic [BYTE_W-1:0]    d_byte;
    logic                 emit;
    logic                 done;
    logic                 we;
    logic                 load_d;

    always_comb begin
        out_free    = !r_o_valid || i_out_ready;
        d_adv       = r_d_valid && out_free;
        can_issue   = !r_d_valid || d_adv;

        match_dist  = i_cmd.data[DIST_W-1:0];
        diff        = {1'b0, r_wpos} - (AW+1)'(match_dist);
        src0        = diff[AW] ? AW'(diff + WIN_EXT) : diff[AW-1:0];

        start_lit   = !r_busy && i_cmd_valid && !i_cmd.is_match && can_issue;
        // A match starts only with the data stage empty, so the write position is final.
        start_match = !r_busy && i_cmd_valid && i_cmd.is_match && !r_d_valid;
        issue_cont  = r_busy && can_issue;
        re          = start_match || issue_cont;
        load_d      = start_lit || re;
        ra          = r_busy ? r_src : src0;
        src_inc     = (ra == LAST_ADDR) ? '0 : ra + 1'b1;
        // Entries past the fill point were never written and read as zero.
        fill_ok     = r_wrapped || (ra < r_wpos);

        if (r_d_lit) begin
            d_byte = r_d_litbyte;
        end else if (r_byp) begin
            d_byte = r_byp_data;
        end else if (r_d_fill) begin
            d_byte = r_rd;
        end else begin
            d_byte = '0;
        end

        emit = r_produced < r_out_len;
        done = emit && ((r_produced + 32'd1) == r_out_len);
        we   = d_adv && emit;
    end

    assign o_cmd_pop     = start_lit || start_match;
    assign o_out_valid   = r_o_valid;
    assign o_out_byte    = r_o_byte;
    assign o_run_last    = r_o_last;
    assign o_stream_done = r_o_done;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_window[r_wpos] <= d_byte;
        end
        if (re) begin
            r_rd <= r_window[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_len  <= '0;
            r_produced <= '0;
            r_wpos     <= '0;
            r_wrapped  <= 1'b0;
            r_busy     <= 1'b0;
            r_rem      <= '0;
            r_d_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_out_len <= i_cfg_data;
            end

            if (load_d) begin
                r_d_valid <= 1'b1;
            end else if (d_adv) begin
                r_d_valid <= 1'b0;
            end

            if (start_match) begin
                r_busy <= 1'b1;
                r_rem  <= {1'b0, i_cmd.data[WORD_W-1:DIST_W]} + 5'd1;
            end else if (issue_cont) begin
                r_rem <= r_rem - 5'd1;
                if (r_rem == 5'd1) begin
                    r_busy <= 1'b0;
                end
            end

            if (we) begin
                r_produced <= r_produced + 32'd1;
                if (r_wpos == LAST_ADDR) begin
                    r_wpos    <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_wpos <= r_wpos + 1'b1;
                end
            end

            if (we) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_d) begin
            r_d_lit     <= start_lit;
            r_d_litbyte <= i_cmd.data[BYTE_W-1:0];
            r_d_last    <= start_lit || (issue_cont && (r_rem == 5'd1));
            r_d_fill    <= fill_ok;
            // A read of the entry being written in the same cycle takes the new byte.
            r_byp       <= we && (r_wpos == ra);
            r_byp_data  <= d_byte;
        end
        if (re) begin
            r_src <= src_inc;
        end
        if (we) begin
            r_o_byte <= d_byte;
            r_o_last <= r_d_last || done;
            r_o_done <= done;
        end
    end

`ifndef ASSERT_OFF
    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_wrapped |-> (r_produced == OUT_LEN_W'(r_wpos)))
        else $error("write position out of step with produced count");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_done |-> r_o_last)
        else $error("stream done without run end");

    a_busy_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem != '0))
        else $error("copy engine busy with no bytes left");

    a_wpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wpos <= LAST_ADDR) && (!r_busy || (r_src <= LAST_ADDR)))
        else $error("window address beyond window size");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_produced < r_out_len) && d_adv)
        else $error("window write past the output length");
`endif

endmodule

// ===== hw/rtl/lzss_window_decoder.sv =====
// Top level of the LZSS window decoder.
// Compressed bytes enter one item per cycle, while the queue is not full, into a
// token parser, which hands literal and match commands through a two-entry queue
// to a copy engine that owns the ring window and emits one decompressed byte per
// cycle, while the output register can drain, into that output register. A flag
// byte or the low byte of a match word yields nothing; with the copy engine idle,
// a literal passes through the queue, the data stage and the output register; a
// match of length L (2 to 17) takes L window reads and starts only once the data
// stage is empty, since the window RAM has a registered read port and the
// source address is formed from the settled write position. The window is not
// cleared after reset: a fill count makes unwritten entries read as zero, so
// items are accepted from the first cycle after reset. Bytes beyond the
// configured output length are parsed and dropped. The output length register
// is always ready and must only be written while the decoder is idle.
module lzss_window_decoder import lzsw_pkg::*; #(
    parameter int WINDOW_SIZE = 8192
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [BYTE_W-1:0]    i_in_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [BYTE_W-1:0]    o_out_byte,
    output logic                 o_run_last,
    output logic                 o_stream_done,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [OUT_LEN_W-1:0] i_cfg_data
);

    logic push;
    t_cmd push_cmd;
    logic full;
    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    assign o_cfg_ready = 1'b1;

    lzsw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_full     (full),
        .o_push     (push),
        .o_push_cmd (push_cmd)
    );

    lzsw_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (full),
        .o_valid    (cmd_valid),
        .o_cmd      (cmd),
        .i_pop      (cmd_pop)
    );

    lzsw_back #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_pop     (cmd_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_stream_done (o_stream_done)
    );

endmodule

// ===== dv/tb_lzss_window_decoder.sv =====
// Self-checking testbench for the LZSS window decoder with random handshake pressure.
`timescale 1ns / 1ps

module tb_lzss_window_decoder;
    import lzsw_pkg::*;

    localparam int WIN           = 8192;
    localparam int DRAIN_CYCLES  = 120;
    localparam int LONG_STALL    = 400;
    localparam int PHASE_ITEMS   = 52;
    localparam int RANDOM_PHASES = 8;
    localparam logic [31:0] NO_LIMIT = 32'hFFFF_FFFF;

    // Literals at the extremes, a zero-distance match, a maximum-distance match,
    // a self-overlapping match and a short match.
    localparam logic [0:12][7:0] DIRECTED_GROUP = {
        8'hAA, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
        8'h5A, 8'h01, 8'hF0, 8'hA5, 8'h03, 8'h30
    };

    typedef enum logic [1:0] {
        EXPECT_FLAG,
        EXPECT_TOKEN,
        EXPECT_MATCH_HI
    } t_parse;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
    } t_decoded;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [BYTE_W-1:0]    i_in_byte = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [BYTE_W-1:0]    o_out_byte;
    logic                 o_run_last;
    logic                 o_stream_done;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [OUT_LEN_W-1:0] i_cfg_data = '0;

    // Decoder state as the predictor sees it.
    logic [7:0]  window_copy [WIN];
    logic [31:0] bytes_made;
    logic [31:0] length_limit;
    logic [7:0]  flag_shift;
    int          tokens_pending;
    t_parse      parse_state;
    logic [7:0]  match_lo;

    logic [7:0] compressed_in [$];
    t_decoded   decoded_expected [$];

    int  items_queued = 0;
    int  mismatches = 0;
    int  send_wait = 0;
    int  recv_wait = 0;
    bit  in_offer;
    bit  send_steady = 1'b0;
    bit  recv_steady = 1'b0;
    bit  stall_request = 1'b0;
    bit  stall_taken = 1'b0;

    lzss_window_decoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_stream_done (o_stream_done),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap(input bit steady);
        return steady ? 0 : int'($urandom_range(0, 12));
    endfunction

    task automatic emit_window_byte(input logic [7:0] v, inout t_decoded run [$]);
        t_decoded d;
        if (bytes_made >= length_limit) return;
        window_copy[bytes_made % WIN] = v;
        bytes_made++;
        d.data = v;
        d.last = 1'b0;
        d.done = (bytes_made == length_limit);
        run.push_back(d);
    endtask

    task automatic close_token();
        flag_shift = flag_shift >> 1;
        tokens_pending = (tokens_pending - 1) & 15;
        parse_state = (tokens_pending == 0) ? EXPECT_FLAG : EXPECT_TOKEN;
    endtask

    task automatic decode_compressed_byte(input logic [7:0] b);
        t_decoded    run [$];
        logic [15:0] word;
        int unsigned distance, len, src;
        case (parse_state)
            EXPECT_TOKEN: begin
                if (!flag_shift[0]) begin
                    emit_window_byte(b, run);
                    close_token();
                end else begin
                    match_lo = b;
                    parse_state = EXPECT_MATCH_HI;
                end
            end
            EXPECT_MATCH_HI: begin
                word = {b, match_lo};
                distance = 32'(word[11:0]);
                len = 32'(word[15:12]) + 32'd2;
                // The source byte is read before the write, so a zero distance
                // replays the old content at the write position.
                src = ((bytes_made % WIN) + WIN - distance) % WIN;
                for (int k = 0; k < len; k++) begin
                    emit_window_byte(window_copy[src], run);
                    src = (src + 1) % WIN;
                end
                close_token();
            end
            default: begin
                flag_shift = b;
                tokens_pending = 8;
                parse_state = EXPECT_TOKEN;
            end
        endcase
        if (run.size() != 0) run[run.size() - 1].last = 1'b1;
        foreach (run[i]) decoded_expected.push_back(run[i]);
    endtask

    task automatic check_decoded();
        t_decoded got, want;
        got = {o_out_byte, o_run_last, o_stream_done};
        if (decoded_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected item byte=%02h last=%0b done=%0b",
                         got.data, got.last, got.done);
        end else begin
            want = decoded_expected.pop_front();
            if (got != want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: expected byte=%02h last=%0b done=%0b, ",
                              "got byte=%02h last=%0b done=%0b"},
                             want.data, want.last, want.done,
                             got.data, got.last, got.done);
            end
        end
    endtask

    // Sender: offers the queued compressed bytes with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_wait = 0;
        end else begin
            in_offer = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                decode_compressed_byte(i_in_byte);
                in_offer = 1'b0;
                send_wait = pick_gap(send_steady);
            end
            if (!in_offer) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (compressed_in.size() != 0) begin
                    i_in_byte <= compressed_in.pop_front();
                    in_offer = 1'b1;
                end
            end
            i_in_valid <= in_offer;
        end
    end

    // Receiver: checks every accepted item and stalls at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                check_decoded();
                recv_wait = pick_gap(recv_steady);
            end
            if (stall_request && !stall_taken) begin
                stall_taken = 1'b1;
                recv_wait = LONG_STALL;
            end
            if (recv_wait > 0) begin
                recv_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        compressed_in.push_back(b);
        items_queued++;
    endtask

    task automatic push_match();
        logic [11:0] match_dist;
        logic [3:0]  len_code;
        case ($urandom_range(0, 5))
            0:       match_dist = '0;
            1:       match_dist = 12'($urandom_range(0, 4095));
            default: match_dist = 12'($urandom_range(1, 64));
        endcase
        len_code = 4'($urandom_range(0, 15));
        push_byte(match_dist[7:0]);
        push_byte({len_code, match_dist[11:8]});
    endtask

    task automatic push_group();
        logic [7:0] flags;
        flags = 8'($urandom_range(0, 255));
        push_byte(flags);
        for (int k = 0; k < 8; k++) begin
            if (flags[k]) push_match();
            else push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Finishes a group left open by noise so that the next group parses as intended.
    task automatic complete_group();
        logic [7:0] fb;
        int         t;
        fb = flag_shift;
        t = tokens_pending;
        if (parse_state == EXPECT_FLAG) return;
        if (parse_state == EXPECT_MATCH_HI) begin
            push_byte(8'($urandom_range(0, 255)));
            fb = fb >> 1;
            t--;
        end
        while (t > 0) begin
            if (fb[0]) push_match();
            else push_byte(8'($urandom_range(0, 255)));
            fb = fb >> 1;
            t--;
        end
    endtask

    task automatic wait_idle();
        int quiet;
        quiet = 0;
        while (quiet < DRAIN_CYCLES) begin
            @(posedge i_clk);
            if (compressed_in.size() != 0 || i_in_valid || decoded_expected.size() != 0)
                quiet = 0;
            else
                quiet++;
        end
    endtask

    task automatic write_length_limit(input logic [31:0] v);
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        length_limit = v;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_directed_group();
        for (int k = 0; k <= 12; k++) push_byte(DIRECTED_GROUP[k]);
    endtask

    initial begin
        int start;
        foreach (window_copy[i]) window_copy[i] = 8'h00;
        bytes_made = '0;
        length_limit = '0;
        flag_shift = '0;
        tokens_pending = 0;
        parse_state = EXPECT_FLAG;
        match_lo = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With the reset length of zero the whole group is parsed and dropped.
        push_directed_group();
        wait_idle();

        // A limit of 20 cuts the long match short and drops the rest of the group.
        write_length_limit(32'd20);
        push_directed_group();
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                1:       write_length_limit(bytes_made + $urandom_range(1, 40));
                3:       write_length_limit(32'd0);
                4:       write_length_limit($urandom());
                5:       write_length_limit(bytes_made);
                6:       write_length_limit(bytes_made + $urandom_range(20, 200));
                default: write_length_limit(NO_LIMIT);
            endcase
            send_steady = (ph == 2) || ($urandom_range(0, 3) == 0);
            recv_steady = ($urandom_range(0, 3) == 0);
            complete_group();
            start = items_queued;
            while (items_queued - start < PHASE_ITEMS) push_group();
            if ($urandom_range(0, 1) == 1)
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
            // The receiver holds off while the sender keeps the input busy.
            if (ph == 2) stall_request = 1'b1;
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
